>>> rtl/core/rmwq_pkg.sv
// Shared types and constants for the recursive mutex wait queue.
package rmwq_pkg;

  localparam int MAX_WAITERS_DEF = 128;
  localparam logic [30:0] LEVEL_MAX = 31'h7fffffff;

  typedef enum logic [2:0] {
    OP_LOCK     = 3'd0,
    OP_TRY_LOCK = 3'd1,
    OP_UNLOCK   = 3'd2,
    OP_CANCEL   = 3'd3,
    OP_END      = 3'd4,
    OP_EXPIRE   = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_OK                = 4'd0,
    ST_ILLEGAL_COUNT     = 4'd1,
    ST_OVERFLOW          = 4'd2,
    ST_RECURSIVE_REFUSED = 4'd3,
    ST_QUEUED            = 4'd4,
    ST_LOCKED            = 4'd5,
    ST_NOT_OWNER         = 4'd6,
    ST_UNDERFLOW         = 4'd7,
    ST_QUEUE_FULL        = 4'd8,
    ST_NOT_WAITING       = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    SCAN_MATCH,
    SCAN_HEAD,
    SCAN_MIN
  } scan_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE,
    S_OUT
  } fsm_t;

  localparam logic CFG_RECURSIVE = 1'b0;
  localparam logic CFG_PRIORITY  = 1'b1;

  typedef struct packed {
    logic [7:0]  thread;
    logic [30:0] count;
    logic [6:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   found;
    entry_t ent;
  } scan_t;

  typedef struct packed {
    scan_mode_t mode;
    logic       shift;
    logic       load;
    logic [7:0] key;
    entry_t     new_ent;
  } cell_cmd_t;

endpackage

>>> rtl/core/recursive_mutex_wait_queue.sv
// Top level of the recursive mutex with a wait queue built as a row of cells.
//
// Usage: one request item enters on in_valid/in_stall (operation, thread_id,
// count, priority_req); exactly one result item leaves on out_valid/out_stall.
// The block takes one item at a time: in_stall is low only while it is idle.
// Lock, try-lock, unlock without handoff, cancel and unused codes finish in S_EXEC,
// which sets out_valid; the block then passes through S_OUT before the next item.
// A handoff, a wait expiry or a thread end walks the queue through the row of
// cells, one cell per cycle, in S_SCAN before the result is set in S_DONE. A thread
// end that releases a lock it owns while others still wait walks it twice: first
// to find its own entry, then to choose the waiter that takes the lock.
// The result stays in its output register while out_stall is high; the next
// item is accepted once it has been taken.
// Configuration (cfg_index 0 recursive_allowed, 1 priority_order) is taken on
// cfg_valid, cfg_ready is always high; write it only while idle.
// Reset (rst, synchronous) unlocks the mutex, empties the queue, clears both
// configuration bits and drops any pending result.
module recursive_mutex_wait_queue #(
  parameter int MAX_WAITERS = rmwq_pkg::MAX_WAITERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  thread_id,
  input  logic signed [31:0] count,
  input  logic [6:0]  priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        granted,
  output logic [7:0]  granted_thread,
  output logic [7:0]  waiter_total,
  output logic [30:0] level_now,
  output logic [7:0]  owner_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import rmwq_pkg::*;

  localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int LW = $clog2(MAX_WAITERS + 1);

  fsm_t state, state_next;
  logic rec, prio_ord;
  logic [30:0] depth, depth_next;
  logic [7:0]  owner, owner_next;
  logic [LW-1:0] len, len_next;
  op_t         op_q;
  logic [7:0]  tid_q;
  logic [31:0] cnt_q;
  logic [6:0]  prio_q;
  scan_mode_t  mode, mode_next;
  logic [IW-1:0] ctr;
  logic        start_scan, finish;
  status_t     st_next;
  logic        gr_next;
  logic [7:0]  gth_next;
  logic        cancel_total;
  logic        shift, load;
  logic [IW-1:0] rm_idx;
  cell_cmd_t   cmd;

  entry_t        ents [MAX_WAITERS];
  scan_t         carry [MAX_WAITERS+1];
  logic [IW-1:0] cidx [MAX_WAITERS+1];

  assign carry[0] = '0;
  assign cidx[0]  = '0;

  assign cmd = '{mode: mode, shift: shift, load: load, key: tid_q,
                 new_ent: '{thread: tid_q, count: cnt_q[30:0], prio: prio_q}};

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    entry_t right;
    if (i == MAX_WAITERS - 1) begin : g_last
      assign right = ents[i];
    end else begin : g_mid
      assign right = ents[i+1];
    end
    rmwq_cell #(.IDX(i), .IW(IW), .LW(LW)) u_cell (
      .clk(clk), .cmd(cmd), .len(len), .rm_idx(rm_idx), .right_ent(right),
      .ent(ents[i]), .cin(carry[i]), .idx_in(cidx[i]),
      .cout(carry[i+1]), .idx_out(cidx[i+1])
    );
  end

  scan_t         res;
  logic [IW-1:0] res_idx;
  assign res     = carry[MAX_WAITERS];
  assign res_idx = cidx[MAX_WAITERS];

  // request decode helpers
  logic        cnt_pos, cnt_big, chk_ok, ovf;
  logic [31:0] sum;
  logic [30:0] diff;
  logic [LW-1:0] len_dec;
  assign cnt_pos = !cnt_q[31] && (cnt_q != 32'd0);
  assign cnt_big = cnt_pos && (cnt_q[30:1] != 30'd0);
  assign chk_ok  = cnt_pos && !(cnt_big && !rec);
  assign sum     = {1'b0, depth} + {1'b0, cnt_q[30:0]};
  assign ovf     = sum[31];
  assign diff    = depth - cnt_q[30:0];
  assign len_dec = len - LW'(1);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // datapath control
  always_comb begin
    depth_next   = depth;
    owner_next   = owner;
    len_next     = len;
    mode_next    = mode;
    start_scan   = 1'b0;
    finish       = 1'b0;
    st_next      = ST_OK;
    gr_next      = 1'b0;
    gth_next     = 8'd0;
    cancel_total = 1'b0;
    shift        = 1'b0;
    load         = 1'b0;
    rm_idx       = res_idx;
    case (state)
      S_EXEC: begin
        finish = 1'b1;
        case (op_q)
          OP_LOCK, OP_TRY_LOCK: begin
            if (!chk_ok) st_next = ST_ILLEGAL_COUNT;
            else if (ovf) st_next = ST_OVERFLOW;
            else if (depth == 31'd0) begin
              depth_next = cnt_q[30:0];
              owner_next = tid_q;
            end else if (owner == tid_q) begin
              if (rec) depth_next = sum[30:0];
              else st_next = ST_RECURSIVE_REFUSED;
            end else if (op_q == OP_TRY_LOCK) st_next = ST_LOCKED;
            else if (len >= LW'(MAX_WAITERS)) st_next = ST_QUEUE_FULL;
            else begin
              load     = 1'b1;
              len_next = len + LW'(1);
              st_next  = ST_QUEUED;
            end
          end
          OP_UNLOCK: begin
            if (!chk_ok) st_next = ST_ILLEGAL_COUNT;
            else if (depth == 31'd0 || owner != tid_q) st_next = ST_NOT_OWNER;
            else if (depth < cnt_q[30:0]) st_next = ST_UNDERFLOW;
            else begin
              depth_next = diff;
              if (diff == 31'd0) begin
                if (len == '0) owner_next = 8'd0;
                else begin
                  finish     = 1'b0;
                  start_scan = 1'b1;
                  mode_next  = prio_ord ? SCAN_MIN : SCAN_HEAD;
                end
              end
            end
          end
          OP_CANCEL: begin
            if (cnt_big && !rec) st_next = ST_ILLEGAL_COUNT;
            else begin
              cancel_total = 1'b1;
              len_next     = '0;
              if (!cnt_pos) begin
                depth_next = 31'd0;
                owner_next = 8'd0;
              end else begin
                depth_next = cnt_q[30:0];
                owner_next = tid_q;
              end
            end
          end
          OP_END, OP_EXPIRE: begin
            finish     = 1'b0;
            start_scan = 1'b1;
            mode_next  = SCAN_MATCH;
          end
          default: ;
        endcase
      end
      S_DONE: begin
        if (mode == SCAN_MATCH) begin
          if (res.found) begin
            shift    = 1'b1;
            len_next = len_dec;
          end
          if (op_q == OP_EXPIRE) begin
            finish = 1'b1;
            if (!res.found) st_next = ST_NOT_WAITING;
          end else if (depth != 31'd0 && owner == tid_q) begin
            if (len_next == '0) begin
              finish     = 1'b1;
              depth_next = 31'd0;
              owner_next = 8'd0;
            end else begin
              start_scan = 1'b1;
              mode_next  = prio_ord ? SCAN_MIN : SCAN_HEAD;
            end
          end else begin
            finish = 1'b1;
          end
        end else begin
          // hand the lock to the chosen waiter and drop its entry
          finish     = 1'b1;
          shift      = 1'b1;
          len_next   = len_dec;
          depth_next = res.ent.count;
          owner_next = res.ent.thread;
          gr_next    = 1'b1;
          gth_next   = res.ent.thread;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = start_scan ? S_SCAN : S_OUT;
      S_SCAN: if (ctr == '0) state_next = S_DONE;
      S_DONE: state_next = start_scan ? S_SCAN : S_OUT;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rec       <= 1'b0;
      prio_ord  <= 1'b0;
      depth     <= 31'd0;
      owner     <= 8'd0;
      len       <= '0;
      mode      <= SCAN_MATCH;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      owner <= owner_next;
      len   <= len_next;
      mode  <= mode_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RECURSIVE) rec <= cfg_data;
        else prio_ord <= cfg_data;
      end
      if (finish) out_valid <= 1'b1;
      else if (state == S_OUT && !out_stall) out_valid <= 1'b0;
    end
  end

  // item capture, scan counter and result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q   <= op_t'(operation);
      tid_q  <= thread_id;
      cnt_q  <= count;
      prio_q <= priority_req;
    end
    if (start_scan) ctr <= IW'(MAX_WAITERS - 1);
    else if (state == S_SCAN) ctr <= ctr - IW'(1);
    if (finish) begin
      status         <= st_next;
      granted        <= gr_next;
      granted_thread <= gth_next;
      waiter_total   <= cancel_total ? 8'(len) : 8'(len_next);
      level_now      <= depth_next;
      owner_now      <= owner_next;
    end
  end

endmodule

>>> rtl/core/rmwq_cell.sv
// One queue slot: holds an entry, shifts toward the head, passes the scan carry on.
module rmwq_cell #(
  parameter int IDX = 0,
  parameter int IW  = 7,
  parameter int LW  = 8
) (
  input  logic               clk,
  input  rmwq_pkg::cell_cmd_t cmd,
  input  logic [LW-1:0]      len,
  input  logic [IW-1:0]      rm_idx,
  input  rmwq_pkg::entry_t   right_ent,
  output rmwq_pkg::entry_t   ent,
  input  rmwq_pkg::scan_t    cin,
  input  logic [IW-1:0]      idx_in,
  output rmwq_pkg::scan_t    cout,
  output logic [IW-1:0]      idx_out
);
  import rmwq_pkg::*;

  logic in_queue;
  logic take;

  assign in_queue = LW'(IDX) < len;

  always_comb begin
    case (cmd.mode)
      SCAN_MATCH: take = in_queue && !cin.found && (ent.thread == cmd.key);
      SCAN_HEAD:  take = in_queue && !cin.found;
      SCAN_MIN:   take = in_queue && (!cin.found || (ent.prio < cin.ent.prio));
      default:    take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cout    <= '{found: 1'b1, ent: ent};
      idx_out <= IW'(IDX);
    end else begin
      cout    <= cin;
      idx_out <= idx_in;
    end
  end

  // close the gap left by a removed entry, or take a new tail entry
  always_ff @(posedge clk) begin
    if (cmd.shift && (IW'(IDX) >= rm_idx)) begin
      ent <= right_ent;
    end else if (cmd.load && (len == LW'(IDX))) begin
      ent <= cmd.new_ent;
    end
  end

endmodule
